FILE: rtl/cuq_pkg.sv
// Shared types and field widths for the coalescing update queue.
package cuq_pkg;

    localparam int TAB_W   = 2;
    localparam int TILE_W  = 4;
    localparam int VALUE_W = 32;
    localparam int UNIT_W  = 16;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic [TAB_W-1:0]   tab;
        logic [TILE_W-1:0]  tile;
        logic [VALUE_W-1:0] value;
        logic [UNIT_W-1:0]  unit;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_POP    = 4'b0100,
        S_POPOUT = 4'b1000
    } t_state;

endpackage

FILE: rtl/coalescing_update_queue.sv
// Coalescing ring queue of pending tile updates, keyed by tab and tile index.
//
// Usage: raise i_start with a command (push or pop) while o_busy is low; the beat
// is taken on that edge. Exactly one result beat follows, shown for a single
// cycle with o_strobe high; the receiver cannot stall it, so capture it then.
// A push first walks the pending entries from oldest to newest through one
// shared key comparator fed by the single registered read port of the entry
// memory, one entry per cycle. On a key match the payload is overwritten in
// place (merged); otherwise the update is appended at the head, dropping the
// oldest entry first when DEPTH-1 entries are already pending. A rejected
// push (tile index at or above TILES) or a pop of an empty queue answers in
// the next cycle with no busy time. A pop holds o_busy through S_POP, while
// the read of the oldest slot is in flight, and S_POPOUT. A push holds o_busy
// in S_SCAN: into an empty queue it goes straight to the write; behind pending
// entries it issues one read per entry, compares the last entry read and then
// writes; a merge writes in place at the compare that hits.
// The next command may be started in the strobe cycle itself.
module coalescing_update_queue
    import cuq_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int TILES = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic               i_op,
    input  logic [TAB_W-1:0]   i_tab,
    input  logic [TILE_W-1:0]  i_tile_index,
    input  logic [VALUE_W-1:0] i_value_word,
    input  logic [UNIT_W-1:0]  i_unit_code,
    output logic               o_strobe,
    output logic               o_rejected,
    output logic               o_merged,
    output logic               o_dropped_oldest,
    output logic               o_pop_valid,
    output logic [TAB_W-1:0]   o_out_tab,
    output logic [TILE_W-1:0]  o_out_tile,
    output logic [VALUE_W-1:0] o_out_value,
    output logic [UNIT_W-1:0]  o_out_unit
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PW-1:0]   LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [TILE_W:0] TILE_LIM  = (TILE_W + 1)'(TILES);

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        ring_next = (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    // Entry memory: one write port, one registered read port.
    t_entry         mem [DEPTH];
    logic           w_en;
    logic [PW-1:0]  w_addr;
    t_entry         w_data;
    t_entry         r_rdata;
    logic [PW-1:0]  r_rd_addr;

    // Control state
    t_state         r_state,   n_state;
    logic [PW-1:0]  r_head,    n_head;
    logic [PW-1:0]  r_tail,    n_tail;
    logic [PW-1:0]  r_scan,    n_scan;
    logic           r_rd_live, n_rd_live;

    // Latched command payload
    t_entry         r_cmd,     n_cmd;

    // Result beat
    logic           r_strobe,  n_strobe;
    logic           r_rejected, n_rejected;
    logic           r_merged,  n_merged;
    logic           r_dropped, n_dropped;
    logic           r_pop_valid, n_pop_valid;
    t_entry         r_out,     n_out;

    logic           key_hit;

    // Shared key comparator: the entry read last cycle against the command key.
    assign key_hit = r_rd_live && (r_rdata.tab == r_cmd.tab) && (r_rdata.tile == r_cmd.tile);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_scan      = r_scan;
        n_rd_live   = 1'b0;
        n_cmd       = r_cmd;
        n_strobe    = 1'b0;
        n_rejected  = r_rejected;
        n_merged    = r_merged;
        n_dropped   = r_dropped;
        n_pop_valid = r_pop_valid;
        n_out       = r_out;
        w_en        = 1'b0;
        w_addr      = r_head;
        w_data      = r_cmd;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd = '{tab: i_tab, tile: i_tile_index,
                              value: i_value_word, unit: i_unit_code};
                    n_scan = r_tail;
                    if (i_op == OP_PUSH) begin
                        if ({1'b0, i_tile_index} >= TILE_LIM) begin
                            // Out-of-range tile: answer at once, leave state alone.
                            n_strobe    = 1'b1;
                            n_rejected  = 1'b1;
                            n_merged    = 1'b0;
                            n_dropped   = 1'b0;
                            n_pop_valid = 1'b0;
                            n_out       = '0;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else if (r_tail == r_head) begin
                        // Empty pop: an all-zero beat.
                        n_strobe    = 1'b1;
                        n_rejected  = 1'b0;
                        n_merged    = 1'b0;
                        n_dropped   = 1'b0;
                        n_pop_valid = 1'b0;
                        n_out       = '0;
                    end else begin
                        n_state = S_POP;
                    end
                end
            end

            S_SCAN: begin
                if (key_hit) begin
                    // Overwrite the payload in place; the key is unchanged.
                    w_en        = 1'b1;
                    w_addr      = r_rd_addr;
                    n_strobe    = 1'b1;
                    n_rejected  = 1'b0;
                    n_merged    = 1'b1;
                    n_dropped   = 1'b0;
                    n_pop_valid = 1'b0;
                    n_out       = '0;
                    n_state     = S_IDLE;
                end else if (!r_rd_live && (r_scan == r_head)) begin
                    // Walk finished without a hit: append, dropping the oldest if full.
                    w_en        = 1'b1;
                    w_addr      = r_head;
                    n_head      = ring_next(r_head);
                    n_dropped   = (ring_next(r_head) == r_tail);
                    if (ring_next(r_head) == r_tail) begin
                        n_tail = ring_next(r_tail);
                    end
                    n_strobe    = 1'b1;
                    n_rejected  = 1'b0;
                    n_merged    = 1'b0;
                    n_pop_valid = 1'b0;
                    n_out       = '0;
                    n_state     = S_IDLE;
                end else if (r_scan != r_head) begin
                    // Issue the next read; its data is compared next cycle.
                    n_rd_live = 1'b1;
                    n_scan    = ring_next(r_scan);
                end
            end

            S_POP: begin
                // Read of the oldest slot is in flight.
                n_state = S_POPOUT;
            end

            S_POPOUT: begin
                n_strobe    = 1'b1;
                n_rejected  = 1'b0;
                n_merged    = 1'b0;
                n_dropped   = 1'b0;
                n_pop_valid = 1'b1;
                n_out       = r_rdata;
                n_tail      = ring_next(r_tail);
                n_state     = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_scan    <= '0;
            r_rd_live <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_scan    <= n_scan;
            r_rd_live <= n_rd_live;
            r_strobe  <= n_strobe;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_rejected  <= n_rejected;
        r_merged    <= n_merged;
        r_dropped   <= n_dropped;
        r_pop_valid <= n_pop_valid;
        r_out       <= n_out;
    end

    // Entry memory: registered read at the scan pointer.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        r_rdata   <= mem[r_scan];
        r_rd_addr <= r_scan;
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_strobe         = r_strobe;
    assign o_rejected       = r_rejected;
    assign o_merged         = r_merged;
    assign o_dropped_oldest = r_dropped;
    assign o_pop_valid      = r_pop_valid;
    assign o_out_tab        = r_out.tab;
    assign o_out_tile       = r_out.tile;
    assign o_out_value      = r_out.value;
    assign o_out_unit       = r_out.unit;

endmodule

FILE: tb/sv/coalescing_update_queue_tb.sv
// Self-checking testbench for the coalescing update queue: directed and random command beats.
module coalescing_update_queue_tb;
    import cuq_pkg::*;

    localparam int DEPTH       = 32;
    localparam int TILES       = 12;
    localparam int KEY_COUNT   = 4 * TILES;    // every tab value, tab three included
    localparam int RANDOM_BEATS = 950;
    // The slowest legal beat is a push that walks the full ring, plus the widest
    // sender gap. Take that many times over.
    localparam int CYCLE_LIMIT = 400000;

    // One result beat as the block presents it.
    typedef struct packed {
        logic               rejected;
        logic               merged;
        logic               dropped_oldest;
        logic               pop_valid;
        logic [TAB_W-1:0]   tab;
        logic [TILE_W-1:0]  tile;
        logic [VALUE_W-1:0] value;
        logic [UNIT_W-1:0]  unit;
    } t_reply;

    // Mirror of the pending-update ring plus the replies it owes.
    class tile_queue_scoreboard;
        t_entry     pending_ring [DEPTH];
        int unsigned oldest_slot;
        int unsigned next_slot;
        t_reply     awaited_replies [$];
        int         fail_count;

        function new();
            oldest_slot = 0;
            next_slot   = 0;
            fail_count  = 0;
        endfunction

        function int unsigned ring_step(int unsigned slot);
            return (slot + 1 == DEPTH) ? 0 : slot + 1;
        endfunction

        // Advance the mirror by one accepted command and note the reply it owes.
        function void apply_command(logic op, logic [TAB_W-1:0] tab, logic [TILE_W-1:0] tile,
                                    logic [VALUE_W-1:0] value, logic [UNIT_W-1:0] unit);
            t_reply      reply;
            int unsigned slot;
            bit          found;
            reply = '0;
            found = 0;
            if (op == OP_PUSH) begin
                if (tile >= TILES) begin
                    reply.rejected = 1'b1;
                end else begin
                    // Walk oldest to newest; the first key hit takes the payload.
                    slot = oldest_slot;
                    while (slot != next_slot && !found) begin
                        if (pending_ring[slot].tab == tab && pending_ring[slot].tile == tile) begin
                            pending_ring[slot].value = value;
                            pending_ring[slot].unit  = unit;
                            found = 1;
                        end else begin
                            slot = ring_step(slot);
                        end
                    end
                    if (found) begin
                        reply.merged = 1'b1;
                    end else begin
                        if (ring_step(next_slot) == oldest_slot) begin
                            oldest_slot = ring_step(oldest_slot);
                            reply.dropped_oldest = 1'b1;
                        end
                        pending_ring[next_slot] = '{tab: tab, tile: tile, value: value, unit: unit};
                        next_slot = ring_step(next_slot);
                    end
                end
            end else if (oldest_slot != next_slot) begin
                reply.pop_valid = 1'b1;
                reply.tab       = pending_ring[oldest_slot].tab;
                reply.tile      = pending_ring[oldest_slot].tile;
                reply.value     = pending_ring[oldest_slot].value;
                reply.unit      = pending_ring[oldest_slot].unit;
                oldest_slot     = ring_step(oldest_slot);
            end
            awaited_replies.push_back(reply);
        endfunction

        function void compare_field(string field, logic [31:0] expected, logic [31:0] actual);
            if (expected !== actual) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, expected, actual);
                fail_count++;
            end
        endfunction

        // Match a result beat against the oldest reply still owed.
        function void check_reply(t_reply actual);
            t_reply expected;
            if (awaited_replies.size() == 0) begin
                $error("result beat with no reply awaited");
                fail_count++;
                return;
            end
            expected = awaited_replies.pop_front();
            compare_field("rejected",       expected.rejected,       actual.rejected);
            compare_field("merged",         expected.merged,         actual.merged);
            compare_field("dropped_oldest", expected.dropped_oldest, actual.dropped_oldest);
            compare_field("pop_valid",      expected.pop_valid,      actual.pop_valid);
            compare_field("out_tab",        expected.tab,            actual.tab);
            compare_field("out_tile",       expected.tile,           actual.tile);
            compare_field("out_value",      expected.value,          actual.value);
            compare_field("out_unit",       expected.unit,           actual.unit);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic               i_op;
    logic [TAB_W-1:0]   i_tab;
    logic [TILE_W-1:0]  i_tile_index;
    logic [VALUE_W-1:0] i_value_word;
    logic [UNIT_W-1:0]  i_unit_code;
    logic               o_strobe;
    logic               o_rejected;
    logic               o_merged;
    logic               o_dropped_oldest;
    logic               o_pop_valid;
    logic [TAB_W-1:0]   o_out_tab;
    logic [TILE_W-1:0]  o_out_tile;
    logic [VALUE_W-1:0] o_out_value;
    logic [UNIT_W-1:0]  o_out_unit;

    tile_queue_scoreboard sb = new();

    // Sender pacing: beats go out in bursts; a steady phase sends back to back.
    int  burst_left;
    bit  steady;
    int  random_sent;

    coalescing_update_queue #(
        .DEPTH (DEPTH),
        .TILES (TILES)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_op             (i_op),
        .i_tab            (i_tab),
        .i_tile_index     (i_tile_index),
        .i_value_word     (i_value_word),
        .i_unit_code      (i_unit_code),
        .o_strobe         (o_strobe),
        .o_rejected       (o_rejected),
        .o_merged         (o_merged),
        .o_dropped_oldest (o_dropped_oldest),
        .o_pop_valid      (o_pop_valid),
        .o_out_tab        (o_out_tab),
        .o_out_tile       (o_out_tile),
        .o_out_value      (o_out_value),
        .o_out_unit       (o_out_unit)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Sample at the rising edge. Inputs only move on the falling edge, so the
    // values seen here are the ones the block registers on this same edge.
    // Check the result first: a new command may be taken in the strobe cycle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                sb.check_reply('{rejected: o_rejected, merged: o_merged,
                                 dropped_oldest: o_dropped_oldest, pop_valid: o_pop_valid,
                                 tab: o_out_tab, tile: o_out_tile,
                                 value: o_out_value, unit: o_out_unit});
            end
            if (i_start && !o_busy) begin
                sb.apply_command(i_op, i_tab, i_tile_index, i_value_word, i_unit_code);
            end
        end
    end

    // Hard stop: a stuck block or a lost reply ends here.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("coalescing_update_queue_tb: errors");
        $finish;
    end

    // Present one command beat and hold it until taken. Called at a falling
    // edge; returns at the falling edge after the accepting rising edge, with
    // i_start still high so a following beat can go out without a gap.
    task automatic send_beat(logic op, logic [TAB_W-1:0] tab, logic [TILE_W-1:0] tile,
                             logic [VALUE_W-1:0] value, logic [UNIT_W-1:0] unit);
        if (burst_left == 0) begin
            if (!steady) begin
                i_start = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_op         = op;
        i_tab        = tab;
        i_tile_index = tile;
        i_value_word = value;
        i_unit_code  = unit;
        i_start      = 1'b1;
        // Busy only moves on a rising edge, so low here means taken at the next one.
        while (o_busy) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic push_update(logic [TAB_W-1:0] tab, logic [TILE_W-1:0] tile,
                               logic [VALUE_W-1:0] value, logic [UNIT_W-1:0] unit);
        send_beat(OP_PUSH, tab, tile, value, unit);
    endtask

    // Pop beats carry random payload bits that the block must ignore.
    task automatic pop_update();
        send_beat(OP_POP, 2'($urandom), 4'($urandom), $urandom, 16'($urandom));
    endtask

    // Hold the sender off until every owed reply has come back.
    task automatic drain_replies();
        i_start = 1'b0;
        while (sb.awaited_replies.size() != 0) @(negedge i_clk);
    endtask

    task automatic push_random(int max_tab, int max_tile);
        push_update(2'($urandom_range(0, max_tab)), 4'($urandom_range(0, max_tile)),
                    $urandom, 16'($urandom));
    endtask

    initial begin
        int phase;
        int beats;
        int key_base;
        int key;

        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_op         = OP_PUSH;
        i_tab        = '0;
        i_tile_index = '0;
        i_value_word = '0;
        i_unit_code  = '0;
        burst_left   = 0;
        steady       = 1'b0;
        random_sent  = 0;
        phase        = 0;

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: empty pop, payload extremes, tab three, both ends of the
        // reject range, merges at oldest and newest, drain past empty.
        pop_update();
        push_update(2'd0, 4'd0, 32'h0000_0000, 16'h0000);
        push_update(2'd3, 4'(TILES - 1), 32'hFFFF_FFFF, 16'hFFFF);
        push_update(2'd0, 4'(TILES), 32'hDEAD_BEEF, 16'h1234);
        push_update(2'd3, 4'd15, 32'hFFFF_FFFF, 16'hFFFF);
        push_update(2'd0, 4'd0, 32'h1234_5678, 16'h0001);
        push_update(2'd3, 4'(TILES - 1), 32'h0000_0000, 16'h0000);
        push_update(2'd2, 4'd5, 32'h8000_0001, 16'h8000);
        push_update(2'd1, 4'd5, 32'h7FFF_FFFE, 16'h7FFF);
        pop_update();
        pop_update();
        pop_update();
        pop_update();
        pop_update();
        push_update(2'd1, 4'd0, 32'hA5A5_A5A5, 16'h5A5A);
        push_update(2'd1, 4'd0, 32'h5A5A_5A5A, 16'hA5A5);
        pop_update();
        pop_update();
        drain_replies();

        // Random phases until enough beats have gone out.
        while (random_sent < RANDOM_BEATS) begin
            steady = ($urandom_range(0, 3) == 0);
            burst_left = 0;
            case ($urandom_range(0, 3))
                0: begin
                    // Fill with consecutive distinct keys so the ring can wrap and
                    // drop its oldest entry; a few pops and rejects as noise.
                    beats    = $urandom_range(20, 48);
                    key_base = $urandom_range(0, KEY_COUNT - 1);
                    for (int i = 0; i < beats; i++) begin
                        key = (key_base + i) % KEY_COUNT;
                        if ($urandom_range(0, 19) == 0) begin
                            push_update(2'($urandom), 4'($urandom_range(TILES, 15)),
                                        $urandom, 16'($urandom));
                        end else if ($urandom_range(0, 9) == 0) begin
                            pop_update();
                        end else begin
                            push_update(2'(key / TILES), 4'(key % TILES),
                                        $urandom, 16'($urandom));
                        end
                    end
                end
                1: begin
                    // Few keys: mostly merges into pending entries.
                    beats = $urandom_range(15, 40);
                    for (int i = 0; i < beats; i++) begin
                        if ($urandom_range(0, 3) == 0) pop_update();
                        else push_random(1, 3);
                    end
                end
                2: begin
                    // Drain, usually well past empty.
                    beats = $urandom_range(4, 40);
                    for (int i = 0; i < beats; i++) begin
                        if ($urandom_range(0, 6) == 0) push_random(3, TILES - 1);
                        else pop_update();
                    end
                end
                default: begin
                    // Anything the fields allow.
                    beats = $urandom_range(15, 40);
                    for (int i = 0; i < beats; i++) begin
                        if ($urandom_range(0, 1) == 0) pop_update();
                        else push_random(3, 15);
                    end
                end
            endcase
            random_sent += beats;
            phase++;
            // Now and then let the block run dry before the next phase.
            if (phase % 3 == 0) drain_replies();
        end

        drain_replies();
        repeat (DEPTH + 8) @(negedge i_clk);
        if (sb.awaited_replies.size() != 0) begin
            $error("%0d replies never arrived", sb.awaited_replies.size());
            sb.fail_count++;
        end
        if (sb.fail_count == 0) begin
            $display("coalescing_update_queue_tb: clean");
        end else begin
            $display("coalescing_update_queue_tb: errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/cuq_pkg.sv
rtl/coalescing_update_queue.sv
tb/sv/coalescing_update_queue_tb.sv
